// ===== src/memory_descriptor_coalescer_core_macros.svh =====
// Assertion macros for the descriptor coalescer checks.
`ifndef MEMORY_DESCRIPTOR_COALESCER_CORE_MACROS_SVH
`define MEMORY_DESCRIPTOR_COALESCER_CORE_MACROS_SVH

// Same-cycle implication.
`define MDC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("descriptor coalescer check failed");

// Next-cycle implication.
`define MDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("descriptor coalescer check failed");

`endif

// ===== src/mdc_pkg.sv =====
`default_nettype none

package mdc_pkg;

    localparam int TYPE_W     = 32;
    localparam int ADDR_W     = 64;
    localparam int PAGE_W     = 52;
    localparam int ATTR_W     = 64;
    localparam int PAGE_SHIFT = 12;

    localparam logic [TYPE_W-1:0] TYPE_LOADER_CODE  = 32'd1;
    localparam logic [TYPE_W-1:0] TYPE_LOADER_DATA  = 32'd2;
    localparam logic [TYPE_W-1:0] TYPE_BS_CODE      = 32'd3;
    localparam logic [TYPE_W-1:0] TYPE_BS_DATA      = 32'd4;
    localparam logic [TYPE_W-1:0] TYPE_RT_CODE      = 32'd5;
    localparam logic [TYPE_W-1:0] TYPE_RT_DATA      = 32'd6;
    localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 32'd7;

    // Join class: two descriptors can only merge when their classes match
    // and are not CLS_OTHER.
    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_FREE,
        CLS_RT_CODE,
        CLS_RT_DATA
    } mem_class_t;

    typedef struct packed {
        logic [TYPE_W-1:0] mem_type;
        logic [ADDR_W-1:0] phys_start;
        logic [PAGE_W-1:0] page_count;
        logic [ATTR_W-1:0] attr_bits;
        logic              is_last;
        mem_class_t        cls;
    } item_t;

    typedef struct packed {
        logic [TYPE_W-1:0] out_type;
        logic [ADDR_W-1:0] out_start;
        logic [PAGE_W-1:0] out_pages;
        logic [ATTR_W-1:0] out_attr;
        logic              out_last;
    } out_desc_t;

    function automatic mem_class_t mem_class(input logic [TYPE_W-1:0] t);
        mem_class_t c;
        unique case (t) inside
            TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BS_CODE, TYPE_BS_DATA,
            TYPE_CONVENTIONAL: c = CLS_FREE;
            TYPE_RT_CODE:      c = CLS_RT_CODE;
            TYPE_RT_DATA:      c = CLS_RT_DATA;
            default:           c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/mdc_if.sv =====
`default_nettype none

interface mdc_in_if;
    logic                         valid;
    logic                         ready;
    logic [mdc_pkg::TYPE_W-1:0]   mem_type;
    logic [mdc_pkg::ADDR_W-1:0]   phys_start;
    logic [mdc_pkg::PAGE_W-1:0]   page_count;
    logic [mdc_pkg::ATTR_W-1:0]   attr_bits;
    logic                         is_last;

    modport source (output valid, mem_type, phys_start, page_count, attr_bits, is_last,
                    input ready);
    modport sink   (input valid, mem_type, phys_start, page_count, attr_bits, is_last,
                    output ready);
endinterface

interface mdc_out_if;
    logic                         valid;
    logic                         ready;
    logic [mdc_pkg::TYPE_W-1:0]   out_type;
    logic [mdc_pkg::ADDR_W-1:0]   out_start;
    logic [mdc_pkg::PAGE_W-1:0]   out_pages;
    logic [mdc_pkg::ATTR_W-1:0]   out_attr;
    logic                         out_last;

    modport source (output valid, out_type, out_start, out_pages, out_attr, out_last,
                    input ready);
    modport sink   (input valid, out_type, out_start, out_pages, out_attr, out_last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/mdc_front.sv =====
`default_nettype none

// Input register stage; tags each beat with its join class.
module mdc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mdc_in_if.sink              desc_in,
    output mdc_pkg::item_t      item,
    output logic                item_valid,
    input  wire logic           item_ready
);
    import mdc_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    assign desc_in.ready = !valid_reg || item_ready;
    assign load          = desc_in.valid && desc_in.ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (desc_in.ready)
        begin
            valid_reg <= desc_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.mem_type   <= desc_in.mem_type;
            item_reg.phys_start <= desc_in.phys_start;
            item_reg.page_count <= desc_in.page_count;
            item_reg.attr_bits  <= desc_in.attr_bits;
            item_reg.is_last    <= desc_in.is_last;
            item_reg.cls        <= mem_class(desc_in.mem_type);
        end
    end

endmodule

`default_nettype wire

// ===== src/mdc_queue.sv =====
`default_nettype none

// Small FIFO between front and back.
module mdc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mdc_pkg::item_t wr_item,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    output mdc_pkg::item_t      rd_item,
    output logic                rd_valid,
    input  wire logic           rd_ready
);
    import mdc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              wr_en;
    logic              rd_en;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_item  = slots[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/mdc_back.sv =====
`default_nettype none

// Holds the pending descriptor, merges or emits, drives the output register.
module mdc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mdc_pkg::item_t item,
    input  wire logic           item_valid,
    output logic                item_ready,
    mdc_out_if.source           desc_out
);
    import mdc_pkg::*;

    localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

    // control
    logic held_valid_reg, held_valid_next;
    logic flush_reg, flush_next;
    logic out_valid_reg, out_valid_next;

    // payload
    logic [TYPE_W-1:0] held_type_reg, held_type_next;
    logic [ADDR_W-1:0] held_start_reg, held_start_next;
    logic [PAGE_W-1:0] held_pages_reg, held_pages_next;
    logic [ATTR_W-1:0] held_attr_reg, held_attr_next;
    mem_class_t        held_cls_reg, held_cls_next;
    out_desc_t         out_reg, out_next;

    logic [ADDR_W-1:0] held_end;
    logic              adjacent;
    logic              join_ok;
    logic [PAGE_W:0]   page_sum;
    logic [PAGE_W-1:0] page_sat;
    logic              needs_out;
    logic              out_free;
    logic              consume;

    assign held_end  = held_start_reg + {held_pages_reg, {PAGE_SHIFT{1'b0}}};
    assign adjacent  = (item.attr_bits == held_attr_reg) && (held_end == item.phys_start);
    assign join_ok   = held_valid_reg && adjacent && (item.cls == held_cls_reg)
                       && (item.cls != CLS_OTHER);
    assign page_sum  = {1'b0, held_pages_reg} + {1'b0, item.page_count};
    assign page_sat  = page_sum[PAGE_W] ? PAGE_MAX : page_sum[PAGE_W-1:0];
    assign out_free  = !out_valid_reg || desc_out.ready;
    assign needs_out = item.is_last || (held_valid_reg && !join_ok);
    assign consume   = !flush_reg && item_valid && (!needs_out || out_free);

    assign item_ready         = consume;
    assign desc_out.valid     = out_valid_reg;
    assign desc_out.out_type  = out_reg.out_type;
    assign desc_out.out_start = out_reg.out_start;
    assign desc_out.out_pages = out_reg.out_pages;
    assign desc_out.out_attr  = out_reg.out_attr;
    assign desc_out.out_last  = out_reg.out_last;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        flush_next      = flush_reg;
        out_valid_next  = out_valid_reg && !desc_out.ready;
        held_type_next  = held_type_reg;
        held_start_next = held_start_reg;
        held_pages_next = held_pages_reg;
        held_attr_next  = held_attr_reg;
        held_cls_next   = held_cls_reg;
        out_next        = out_reg;

        if (flush_reg)
        begin
            // second beat of a non-joining last descriptor
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_next        = '{held_type_reg, held_start_reg, held_pages_reg,
                                    held_attr_reg, 1'b1};
                held_valid_next = 1'b0;
                flush_next      = 1'b0;
            end
        end
        else if (consume)
        begin
            if (!held_valid_reg)
            begin
                if (item.is_last)
                begin
                    // one-entry map passes through
                    out_valid_next = 1'b1;
                    out_next       = '{item.mem_type, item.phys_start, item.page_count,
                                       item.attr_bits, 1'b1};
                end
                else
                begin
                    held_valid_next = 1'b1;
                    held_type_next  = item.mem_type;
                    held_start_next = item.phys_start;
                    held_pages_next = item.page_count;
                    held_attr_next  = item.attr_bits;
                    held_cls_next   = item.cls;
                end
            end
            else if (join_ok)
            begin
                held_pages_next = page_sat;
                if (item.cls == CLS_FREE)
                begin
                    held_type_next = TYPE_CONVENTIONAL;
                end
                if (item.is_last)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = '{held_type_next, held_start_reg, page_sat,
                                        held_attr_reg, 1'b1};
                    held_valid_next = 1'b0;
                end
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_next        = '{held_type_reg, held_start_reg, held_pages_reg,
                                    held_attr_reg, 1'b0};
                held_type_next  = item.mem_type;
                held_start_next = item.phys_start;
                held_pages_next = item.page_count;
                held_attr_next  = item.attr_bits;
                held_cls_next   = item.cls;
                flush_next      = item.is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            flush_reg      <= flush_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_type_reg  <= held_type_next;
        held_start_reg <= held_start_next;
        held_pages_reg <= held_pages_next;
        held_attr_reg  <= held_attr_next;
        held_cls_reg   <= held_cls_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

// ===== src/memory_descriptor_coalescer_core.sv =====
// Path: a last descriptor passes the input register, the queue and the output register;
// when the pending one has to go out ahead of it, it first waits in the pending register.
// Throughput: 1 descriptor per cycle while desc_out does not stall; a non-joining last
// descriptor adds a flush step at the back stage, which emits pending and new in turn.
// Reset: rst_n is asynchronous, active low; it empties the input stage, the queue,
// the pending descriptor and the output register.
`default_nettype none

// Structure:
//   front - input register, tags each beat with its join class
//   queue - QUEUE_DEPTH-entry FIFO so front and back stall independently
//   back  - pending descriptor, adjacency check (one 64-bit add and compare),
//           saturating page add, output register
// The output register holds a finished descriptor until desc_out.ready: a beat that merges
// into the pending descriptor is still taken while it waits, a beat that must emit is not.
module memory_descriptor_coalescer_core #(
    parameter int QUEUE_DEPTH = 2   // 2 or more
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mdc_in_if.sink    desc_in,
    mdc_out_if.source desc_out
);
    import mdc_pkg::*;

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t back_item;
    logic  back_valid;
    logic  back_ready;

    mdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_in    (desc_in),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    mdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (back_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    // Merge decision and the pending descriptor live here.
    mdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .desc_out   (desc_out)
    );

endmodule

`default_nettype wire

// ===== src/mdc_checker.sv =====
`default_nettype none
`include "memory_descriptor_coalescer_core_macros.svh"

module mdc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [mdc_pkg::TYPE_W-1:0]  out_type,
    input wire logic [mdc_pkg::ADDR_W-1:0]  out_start,
    input wire logic [mdc_pkg::PAGE_W-1:0]  out_pages,
    input wire logic [mdc_pkg::ATTR_W-1:0]  out_attr,
    input wire logic                        out_last
);
    import mdc_pkg::*;

    logic                                    out_acc;
    logic [TYPE_W+ADDR_W+PAGE_W+ATTR_W:0]    out_payload;
    logic                                    prev_acc_reg;
    logic                                    prev_last_reg;
    mem_class_t                              prev_cls_reg;
    logic [ADDR_W-1:0]                       prev_end_reg;
    logic [ATTR_W-1:0]                       prev_attr_reg;
    logic                                    chain_ok;

    assign out_acc     = out_valid && out_ready;
    assign out_payload = {out_type, out_start, out_pages, out_attr, out_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_acc_reg <= 1'b0;
        end
        else
        begin
            prev_acc_reg <= out_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_last_reg <= out_last;
        prev_cls_reg  <= mem_class(out_type);
        prev_end_reg  <= out_start + {out_pages, {PAGE_SHIFT{1'b0}}};
        prev_attr_reg <= out_attr;
    end

    // two beats in a row from the same map that could have merged
    assign chain_ok = out_acc && prev_acc_reg && !prev_last_reg
                      && (mem_class(out_type) == prev_cls_reg)
                      && (prev_cls_reg != CLS_OTHER) && (out_attr == prev_attr_reg);

    `MDC_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `MDC_ASSERT_NEXT(a_payload_hold, clk, rst_n, out_valid && !out_ready, $stable(out_payload))
    `MDC_ASSERT_IMPLY(a_no_missed_merge, clk, rst_n, chain_ok, out_start != prev_end_reg)

endmodule

bind memory_descriptor_coalescer_core mdc_checker u_mdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (desc_out.valid),
    .out_ready (desc_out.ready),
    .out_type  (desc_out.out_type),
    .out_start (desc_out.out_start),
    .out_pages (desc_out.out_pages),
    .out_attr  (desc_out.out_attr),
    .out_last  (desc_out.out_last)
);

`default_nettype wire
